// ----- rtl/line_rasterizer_unit_assert.svh -----
// Assertion helpers; users provide i_clk and i_rst_n in scope.
`ifndef LINE_RASTERIZER_UNIT_ASSERT_SVH
`define LINE_RASTERIZER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define LR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define LR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/lr_pkg.sv -----
package lr_pkg;

    localparam int COORD_W = 16;
    localparam int DELTA_W = 17;
    localparam int ERR_W   = 19;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_STEP = 1'b1
    } t_op;

    typedef struct packed {
        t_op                        opcode;
        logic signed [COORD_W-1:0]  x_start;
        logic signed [COORD_W-1:0]  y_start;
        logic signed [COORD_W-1:0]  x_end;
        logic signed [COORD_W-1:0]  y_end;
    } t_cmd;

    typedef struct packed {
        logic signed [COORD_W-1:0]  pixel_x;
        logic signed [COORD_W-1:0]  pixel_y;
        logic                       pixel_valid;
        logic                       on_canvas;
        logic                       last_pixel;
    } t_pix;

    // Classified command handed from the front end to the stepper.
    typedef struct packed {
        t_op                        opcode;
        logic [COORD_W-1:0]         run_coord;
        logic [COORD_W-1:0]         run_end;
        logic [COORD_W-1:0]         cross_coord;
        logic signed [ERR_W-1:0]    error_term;
        logic [DELTA_W-1:0]         run_delta;
        logic [DELTA_W-1:0]         cross_delta;
        logic                       steep_mode;
        logic                       step_negative;
    } t_job;

endpackage

// ----- rtl/lr_cmd_if.sv -----
interface lr_cmd_if import lr_pkg::*; ();
    logic valid;
    logic ready;
    t_cmd data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/lr_pix_if.sv -----
interface lr_pix_if import lr_pkg::*; ();
    logic valid;
    logic ready;
    t_pix data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/lr_front.sv -----
`include "line_rasterizer_unit_assert.svh"

module lr_front import lr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    lr_cmd_if.sink  i_cmd,
    output logic    o_job_valid,
    input  logic    i_job_ready,
    output t_job    o_job
);

    typedef struct packed {
        t_op                opcode;
        logic [COORD_W-1:0] x1;
        logic [COORD_W-1:0] y1;
        logic [COORD_W-1:0] x2;
        logic [COORD_W-1:0] y2;
        logic [DELTA_W-1:0] dx;
        logic [DELTA_W-1:0] dxn;
        logic [DELTA_W-1:0] dy;
        logic [DELTA_W-1:0] dyn;
    } t_stage;

    t_stage r_stg;
    logic   r_stg_vld;
    logic   n_stg_vld;
    logic   cmd_acc;
    logic   job_acc;

    logic               swap;
    logic [DELTA_W-1:0] dxs;
    logic [DELTA_W-1:0] dys;
    logic [DELTA_W-1:0] ady;
    logic               neg;
    logic               steep;
    logic [COORD_W-1:0] sx1;
    logic [COORD_W-1:0] sy1;
    logic [COORD_W-1:0] sx2;
    logic [COORD_W-1:0] sy2;
    logic [ERR_W-1:0]   err_shallow;
    logic [ERR_W-1:0]   err_steep;

    assign i_cmd.ready = !r_stg_vld || i_job_ready;
    assign cmd_acc     = i_cmd.valid && i_cmd.ready;
    assign job_acc     = o_job_valid && i_job_ready;

    // Both difference signs are formed up front so the swap is only a select.
    always_ff @(posedge i_clk) begin
        if (cmd_acc) begin
            r_stg.opcode <= i_cmd.data.opcode;
            r_stg.x1     <= i_cmd.data.x_start;
            r_stg.y1     <= i_cmd.data.y_start;
            r_stg.x2     <= i_cmd.data.x_end;
            r_stg.y2     <= i_cmd.data.y_end;
            r_stg.dx     <= {i_cmd.data.x_end[COORD_W-1], i_cmd.data.x_end}
                          - {i_cmd.data.x_start[COORD_W-1], i_cmd.data.x_start};
            r_stg.dxn    <= {i_cmd.data.x_start[COORD_W-1], i_cmd.data.x_start}
                          - {i_cmd.data.x_end[COORD_W-1], i_cmd.data.x_end};
            r_stg.dy     <= {i_cmd.data.y_end[COORD_W-1], i_cmd.data.y_end}
                          - {i_cmd.data.y_start[COORD_W-1], i_cmd.data.y_start};
            r_stg.dyn    <= {i_cmd.data.y_start[COORD_W-1], i_cmd.data.y_start}
                          - {i_cmd.data.y_end[COORD_W-1], i_cmd.data.y_end};
        end
    end

    always_comb begin
        n_stg_vld = r_stg_vld;
        if (cmd_acc) begin
            n_stg_vld = 1'b1;
        end else if (job_acc) begin
            n_stg_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg_vld <= 1'b0;
        end else begin
            r_stg_vld <= n_stg_vld;
        end
    end

    always_comb begin
        swap  = r_stg.dx[DELTA_W-1] || (r_stg.dx == '0);
        dxs   = swap ? r_stg.dxn : r_stg.dx;
        dys   = swap ? r_stg.dyn : r_stg.dy;
        neg   = dys[DELTA_W-1];
        // negated dys is just the other precomputed difference
        ady   = neg ? (swap ? r_stg.dy : r_stg.dyn) : dys;
        steep = !(dxs > ady);
        sx1   = swap ? r_stg.x2 : r_stg.x1;
        sy1   = swap ? r_stg.y2 : r_stg.y1;
        sx2   = swap ? r_stg.x1 : r_stg.x2;
        sy2   = swap ? r_stg.y1 : r_stg.y2;
        err_shallow = {{(ERR_W-DELTA_W){dys[DELTA_W-1]}}, dys}
                    - {{(ERR_W-DELTA_W){1'b0}}, dxs};
        err_steep   = {{(ERR_W-DELTA_W){1'b0}}, dxs}
                    - {{(ERR_W-DELTA_W){dys[DELTA_W-1]}}, dys};
    end

    always_comb begin
        o_job_valid         = r_stg_vld;
        o_job.opcode        = r_stg.opcode;
        o_job.steep_mode    = steep;
        o_job.step_negative = neg;
        if (!steep) begin
            o_job.run_coord   = sx1;
            o_job.run_end     = sx2;
            o_job.cross_coord = sy1;
            o_job.error_term  = $signed(err_shallow);
            o_job.run_delta   = dxs;
            o_job.cross_delta = ady;
        end else begin
            o_job.run_coord   = sy1;
            o_job.run_end     = sy2;
            o_job.cross_coord = sx1;
            o_job.error_term  = $signed(err_steep);
            o_job.run_delta   = ady;
            o_job.cross_delta = dxs;
        end
    end

    `LR_ASSERT_NOW(a_run_dominates, job_acc && (o_job.opcode == OP_LOAD),
        o_job.cross_delta <= o_job.run_delta, "cross delta exceeds run delta")

endmodule

// ----- rtl/lr_queue.sv -----
`include "line_rasterizer_unit_assert.svh"

module lr_queue import lr_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push_valid,
    output logic    o_push_ready,
    input  t_job    i_push_job,
    output logic    o_pop_valid,
    input  logic    i_pop_ready,
    output t_job    o_pop_job
);

    localparam int PtrW = $clog2(DEPTH);
    localparam int CntW = $clog2(DEPTH + 1);

    t_job            r_mem [DEPTH];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_count;
    logic [PtrW-1:0] n_wr_ptr;
    logic [PtrW-1:0] n_rd_ptr;
    logic [CntW-1:0] n_count;
    logic            push;
    logic            pop;

    assign o_push_ready = (r_count != CntW'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_job    = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PtrW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PtrW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    `LR_ASSERT_NEXT(a_fill_grows, push && !pop, r_count == $past(r_count) + 1'b1,
        "queue fill did not track a lone push")

endmodule

// ----- rtl/lr_back.sv -----
`include "line_rasterizer_unit_assert.svh"

module lr_back import lr_pkg::*; #(
    parameter int CANVAS_SIZE = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_job_valid,
    output logic        o_job_ready,
    input  t_job        i_job,
    lr_pix_if.source    o_pix
);

    localparam logic [COORD_W-1:0] CanvasMax = COORD_W'(CANVAS_SIZE - 1);

    logic [COORD_W-1:0] r_run;
    logic [COORD_W-1:0] r_cross;
    logic [COORD_W-1:0] r_end;
    logic [ERR_W-1:0]   r_err;
    logic [DELTA_W-1:0] r_rdelta;
    logic [DELTA_W-1:0] r_cdelta;
    logic               r_steep;
    logic               r_neg;
    logic               r_active;
    t_pix               r_out;
    logic               r_out_vld;

    logic [COORD_W-1:0] n_run;
    logic [COORD_W-1:0] n_cross;
    logic [COORD_W-1:0] n_end;
    logic [ERR_W-1:0]   n_err;
    logic [DELTA_W-1:0] n_rdelta;
    logic [DELTA_W-1:0] n_cdelta;
    logic               n_steep;
    logic               n_neg;
    logic               n_active;
    t_pix               n_out;
    logic               n_out_vld;

    logic               pop;
    logic               is_step;
    logic [COORD_W-1:0] run_nxt;
    logic [COORD_W-1:0] cross_nxt;
    logic [ERR_W-1:0]   err_nxt;
    logic               err_pos;
    logic               run_done;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    logic               load_empty;

    assign o_job_ready = !r_out_vld || o_pix.ready;
    assign pop         = i_job_valid && o_job_ready;
    assign is_step     = (i_job.opcode == OP_STEP);
    assign o_pix.valid = r_out_vld;
    assign o_pix.data  = r_out;

    // One Bresenham step from the current state.
    always_comb begin
        run_nxt   = (r_steep && r_neg) ? r_run - 1'b1 : r_run + 1'b1;
        err_pos   = !r_err[ERR_W-1] && (r_err != '0);
        cross_nxt = r_cross;
        if (err_pos) begin
            cross_nxt = (!r_steep && r_neg) ? r_cross - 1'b1 : r_cross + 1'b1;
        end
        err_nxt   = (err_pos ? r_err - {{(ERR_W-DELTA_W){1'b0}}, r_rdelta} : r_err)
                  + {{(ERR_W-DELTA_W){1'b0}}, r_cdelta};
        run_done  = (run_nxt == r_end);
        px        = r_steep ? r_cross : r_run;
        py        = r_steep ? r_run : r_cross;
        load_empty = (i_job.run_coord == i_job.run_end);
    end

    always_comb begin
        n_run     = r_run;
        n_cross   = r_cross;
        n_end     = r_end;
        n_err     = r_err;
        n_rdelta  = r_rdelta;
        n_cdelta  = r_cdelta;
        n_steep   = r_steep;
        n_neg     = r_neg;
        n_active  = r_active;
        n_out     = r_out;
        n_out_vld = r_out_vld;
        if (o_pix.ready) begin
            n_out_vld = 1'b0;
        end
        if (pop) begin
            n_out_vld = 1'b1;
            n_out     = '0;
            if (!is_step) begin
                n_run    = i_job.run_coord;
                n_cross  = i_job.cross_coord;
                n_end    = i_job.run_end;
                n_err    = i_job.error_term;
                n_rdelta = i_job.run_delta;
                n_cdelta = i_job.cross_delta;
                n_steep  = i_job.steep_mode;
                n_neg    = i_job.step_negative;
                n_active = !load_empty;
                n_out.last_pixel = load_empty;
            end else if (r_active) begin
                n_run    = run_nxt;
                n_cross  = cross_nxt;
                n_err    = err_nxt;
                n_active = !run_done;
                n_out.pixel_x     = $signed(px);
                n_out.pixel_y     = $signed(py);
                n_out.pixel_valid = 1'b1;
                n_out.on_canvas   = !px[COORD_W-1] && (px <= CanvasMax)
                                 && !py[COORD_W-1] && (py <= CanvasMax);
                n_out.last_pixel  = run_done;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_run    <= n_run;
        r_cross  <= n_cross;
        r_end    <= n_end;
        r_err    <= n_err;
        r_rdelta <= n_rdelta;
        r_cdelta <= n_cdelta;
        r_steep  <= n_steep;
        r_neg    <= n_neg;
        r_out    <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_active  <= n_active;
            r_out_vld <= n_out_vld;
        end
    end

    `LR_ASSERT_NEXT(a_line_ends, pop && is_step && r_active && run_done,
        !r_active && r_out_vld && r_out.last_pixel, "final pixel did not close the line")
    `LR_ASSERT_NEXT(a_idle_step, pop && is_step && !r_active,
        r_out_vld && !r_out.pixel_valid && !r_out.last_pixel, "step without line gave a pixel")
    `LR_ASSERT_NOW(a_canvas_valid, r_out_vld && r_out.on_canvas, r_out.pixel_valid,
        "on_canvas set on a result without a pixel")

endmodule

// ----- rtl/line_rasterizer_unit.sv -----
// Bresenham line rasterizer. A load transaction (opcode 0) sets up a line between two
// signed 16-bit endpoints; each step transaction (opcode 1) returns the next pixel, with
// on_canvas flagging 0..CANVAS_SIZE-1 in both axes and last_pixel marking the end (or a
// load of a line with no pixels). Every command returns exactly one result, in order.
// One command is taken and one result delivered per clock when the output is not stalled:
// the stepper updates its error term and coordinates combinationally from its registers. A command passes
// three registers (input stage loaded at the accepting edge, QUEUE_DEPTH-entry queue,
// output register), and its result is read from the output register; the queue lets the
// input side keep accepting while results back up.
module line_rasterizer_unit import lr_pkg::*; #(
    parameter int CANVAS_SIZE = 1024,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lr_cmd_if.sink      i_cmd,
    lr_pix_if.source    o_pix
);

    logic front_valid;
    logic front_ready;
    t_job front_job;
    logic back_valid;
    logic back_ready;
    t_job back_job;

    lr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (i_cmd),
        .o_job_valid (front_valid),
        .i_job_ready (front_ready),
        .o_job       (front_job)
    );

    lr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_push_job   (front_job),
        .o_pop_valid  (back_valid),
        .i_pop_ready  (back_ready),
        .o_pop_job    (back_job)
    );

    lr_back #(
        .CANVAS_SIZE (CANVAS_SIZE)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (back_valid),
        .o_job_ready (back_ready),
        .i_job       (back_job),
        .o_pix       (o_pix)
    );

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench import lr_pkg::*;;

    localparam int CANVAS     = 1024;
    localparam int ITEM_TOTAL = 1140;
    localparam int CALM_AFTER = 1000;
    localparam int STALL_LIMIT = 1000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    lr_cmd_if cmd ();
    lr_pix_if pix ();

    line_rasterizer_unit #(.CANVAS_SIZE(CANVAS)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_pix   (pix)
    );

    // Bresenham predictor plus the queue of pixels still owed by the block.
    class pixel_scoreboard;
        int run_pos;
        int cross_pos;
        int run_stop;
        int bias;
        int run_span;
        int cross_span;
        bit steep;
        bit descending;
        bit drawing;
        t_pix owed[$];
        int mismatches;

        function new();
            run_pos    = 0;
            cross_pos  = 0;
            run_stop   = 0;
            bias       = 0;
            run_span   = 0;
            cross_span = 0;
            steep      = 1'b0;
            descending = 1'b0;
            drawing    = 1'b0;
            mismatches = 0;
        endfunction

        function int outstanding();
            return owed.size();
        endfunction

        function int wrap16(int v);
            return int'($signed(v[15:0]));
        endfunction

        function bit in_canvas(int v);
            return v >= 0 && v <= CANVAS - 1;
        endfunction

        function void note_command(t_cmd c);
            int x1, y1, x2, y2, dx, dy, ady, t, px, py, run_dir, cross_dir;
            t_pix p;
            p = '0;
            if (c.opcode == OP_LOAD) begin
                x1 = c.x_start;
                y1 = c.y_start;
                x2 = c.x_end;
                y2 = c.y_end;
                dx = x2 - x1;
                dy = y2 - y1;
                if (dx <= 0) begin
                    dx = -dx;
                    dy = -dy;
                    t = x1; x1 = x2; x2 = t;
                    t = y1; y1 = y2; y2 = t;
                end
                ady = (dy < 0) ? -dy : dy;
                descending = dy < 0;
                steep = !(dx > ady);
                if (!steep) begin
                    run_pos    = x1;
                    run_stop   = x2;
                    cross_pos  = y1;
                    bias       = dy - dx;
                    run_span   = dx;
                    cross_span = ady;
                end else begin
                    run_pos    = y1;
                    run_stop   = y2;
                    cross_pos  = x1;
                    bias       = dx - dy;
                    run_span   = ady;
                    cross_span = dx;
                end
                drawing = run_pos != run_stop;
                p.last_pixel = !drawing;
            end else if (drawing) begin
                run_dir   = (steep && descending) ? -1 : 1;
                cross_dir = (!steep && descending) ? -1 : 1;
                px = steep ? cross_pos : run_pos;
                py = steep ? run_pos : cross_pos;
                p.pixel_x     = 16'(px);
                p.pixel_y     = 16'(py);
                p.pixel_valid = 1'b1;
                p.on_canvas   = in_canvas(px) && in_canvas(py);
                if (bias > 0) begin
                    cross_pos = wrap16(cross_pos + cross_dir);
                    bias      = bias - run_span;
                end
                bias    = bias + cross_span;
                run_pos = wrap16(run_pos + run_dir);
                if (run_pos == run_stop) begin
                    drawing      = 1'b0;
                    p.last_pixel = 1'b1;
                end
            end
            owed = {owed, p};
        endfunction

        task report(string msg);
            if (mismatches < 40)
                $display("mismatch @%0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_pixel(t_pix got);
            t_pix want;
            if (owed.size() == 0) begin
                report("pixel transaction with no command outstanding");
                return;
            end
            want = owed.pop_front();
            if (got.pixel_x !== want.pixel_x)
                report($sformatf("pixel_x got %0d want %0d", got.pixel_x, want.pixel_x));
            if (got.pixel_y !== want.pixel_y)
                report($sformatf("pixel_y got %0d want %0d", got.pixel_y, want.pixel_y));
            if (got.pixel_valid !== want.pixel_valid)
                report($sformatf("pixel_valid got %b want %b",
                                 got.pixel_valid, want.pixel_valid));
            if (got.on_canvas !== want.on_canvas)
                report($sformatf("on_canvas got %b want %b (x %0d y %0d)",
                                 got.on_canvas, want.on_canvas, want.pixel_x, want.pixel_y));
            if (got.last_pixel !== want.last_pixel)
                report($sformatf("last_pixel got %b want %b",
                                 got.last_pixel, want.last_pixel));
        endtask
    endclass

    pixel_scoreboard sb = new();

    int items_sent  = 0;
    int pixels_seen = 0;
    int quiet_cycles = 0;
    bit calm = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && pix.valid && pix.ready) begin
            sb.check_pixel(pix.data);
            pixels_seen++;
        end
    end

    // watchdog: no transaction on either side for too long
    always @(posedge i_clk) begin
        if ((cmd.valid && cmd.ready) || (pix.valid && pix.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog expired with %0d pixels outstanding", sb.outstanding());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // pixel receiver with random backpressure and one long hold
    initial begin
        int stall_left;
        bit long_hold_done;
        stall_left = 0;
        long_hold_done = 1'b0;
        pix.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!long_hold_done && pixels_seen >= 400) begin
                long_hold_done = 1'b1;
                stall_left = 150;
            end else if (stall_left == 0 && !calm && $urandom_range(0, 6) == 0) begin
                stall_left = $urandom_range(1, 14);
            end
            if (stall_left > 0) begin
                pix.ready <= 1'b0;
                stall_left--;
            end else begin
                pix.ready <= 1'b1;
            end
        end
    end

    task automatic pause_sender(input int n);
        @(negedge i_clk);
        cmd.valid <= 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    task automatic send_cmd(input t_cmd c);
        if (!calm && $urandom_range(0, 5) == 0)
            pause_sender($urandom_range(1, 14));
        @(negedge i_clk);
        cmd.valid <= 1'b1;
        cmd.data  <= c;
        @(posedge i_clk);
        while (!cmd.ready) @(posedge i_clk);
        sb.note_command(c);
        items_sent++;
    endtask

    task automatic load_line(input int x1, input int y1, input int x2, input int y2);
        t_cmd c;
        c.opcode  = OP_LOAD;
        c.x_start = 16'(x1);
        c.y_start = 16'(y1);
        c.x_end   = 16'(x2);
        c.y_end   = 16'(y2);
        send_cmd(c);
    endtask

    // step payload is ignored by the block, so fill it with noise
    task automatic step_pixels(input int n);
        t_cmd c;
        repeat (n) begin
            c.opcode  = OP_STEP;
            c.x_start = 16'($urandom);
            c.y_start = 16'($urandom);
            c.x_end   = 16'($urandom);
            c.y_end   = 16'($urandom);
            send_cmd(c);
        end
    endtask

    task automatic wait_for_drain();
        @(negedge i_clk);
        cmd.valid <= 1'b0;
        while (sb.outstanding() > 0) @(posedge i_clk);
    endtask

    task automatic random_stroke();
        int kind, x1, y1, x2, y2, span, r;
        kind = $urandom_range(0, 19);
        if (kind < 12) begin
            x1 = int'($urandom_range(0, 1067)) - 22;
            y1 = int'($urandom_range(0, 1067)) - 22;
            x2 = x1 + int'($urandom_range(0, 48)) - 24;
            y2 = y1 + int'($urandom_range(0, 48)) - 24;
            load_line(x1, y1, x2, y2);
            step_pixels($urandom_range(0, 52));
        end else if (kind < 14) begin
            load_line($urandom, $urandom, $urandom, $urandom);
            step_pixels($urandom_range(0, 12));
        end else if (kind < 16) begin
            x1 = $urandom;
            y1 = $urandom;
            load_line(x1, y1, x1, y1);
            step_pixels($urandom_range(0, 2));
        end else if (kind == 16) begin
            x1 = int'($urandom_range(0, 1067)) - 22;
            y1 = int'($urandom_range(0, 1067)) - 22;
            span = int'($urandom_range(0, 40)) - 20;
            r = $urandom_range(0, 3);
            x2 = (r == 1) ? x1 : x1 + span;
            y2 = (r == 0) ? y1 : (r == 3) ? y1 - span : y1 + span;
            load_line(x1, y1, x2, y2);
            step_pixels($urandom_range(0, 44));
        end else if (kind < 19) begin
            r  = $urandom_range(0, 20);
            x1 = $urandom_range(0, 1) ? 32767 - r : -32768 + r;
            r  = $urandom_range(0, 20);
            y1 = $urandom_range(0, 1) ? 32767 - r : -32768 + r;
            x2 = x1 + int'($urandom_range(0, 20)) - 10;
            y2 = y1 + int'($urandom_range(0, 20)) - 10;
            load_line(x1, y1, x2, y2);
            step_pixels($urandom_range(0, 25));
        end else begin
            step_pixels($urandom_range(1, 4));
        end
    endtask

    initial begin
        bit paused_mid;
        paused_mid = 1'b0;
        i_rst_n   = 1'b0;
        cmd.valid = 1'b0;
        cmd.data  = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // step before any line, then a line with no pixels
        step_pixels(1);
        load_line(3, 3, 3, 3);
        step_pixels(1);
        // full-range diagonals, one forcing the endpoint swap
        load_line(-32768, -32768, 32767, 32767);
        step_pixels(2);
        load_line(32767, -32768, -32768, 32767);
        step_pixels(1);
        // shallow line running off the right edge of the canvas
        load_line(1021, 0, 1026, 2);
        step_pixels(5);
        // steep descending line, one extra step past its end
        load_line(0, 2, 1, -2);
        step_pixels(5);
        // horizontal line cut short by a vertical one
        load_line(-1, 1023, 1, 1023);
        step_pixels(1);
        load_line(0, 0, 0, -2);
        step_pixels(2);
        wait_for_drain();

        while (items_sent < ITEM_TOTAL) begin
            if (items_sent >= CALM_AFTER)
                calm = 1'b1;
            if (!paused_mid && items_sent >= 600) begin
                wait_for_drain();
                paused_mid = 1'b1;
            end
            random_stroke();
        end

        wait_for_drain();
        repeat (8) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/lr_pkg.sv
rtl/lr_cmd_if.sv
rtl/lr_pix_if.sv
rtl/lr_front.sv
rtl/lr_queue.sv
rtl/lr_back.sv
rtl/line_rasterizer_unit.sv
tb/testbench.sv
